### design/sparse_polynomial_adder_defines.svh
// assertion helpers for the checker file
`ifndef SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH

// same-cycle implication
`define SPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spa check failed");

// next-cycle implication
`define SPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spa check failed");

`endif

### design/spa_pkg.sv
package spa_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = 6;

  typedef enum logic [1:0] {
    REQ_LOAD_FIRST  = 2'd0,
    REQ_LOAD_SECOND = 2'd1,
    REQ_COMPUTE     = 2'd2
  } req_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic        [15:0] exponent;
    logic signed [15:0] coefficient;
  } term_t;

endpackage

### design/spa_term_store.sv
module spa_term_store
  import spa_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  term_t         wr_term,
  input  logic [AW-1:0] rd_addr,
  output term_t         rd_term
);

  term_t mem [DEPTH];
  term_t rd_term_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_term;
    end
  end

  // read every cycle, data registered and ready in the next cycle
  always_ff @(posedge clk) begin
    rd_term_r <= mem[rd_addr];
  end

  assign rd_term = rd_term_r;

endmodule

### design/sparse_polynomial_adder.sv
// loads: one word per cycle while idle, written to the term store on acceptance
// compute: the request enters the merge state; terms come from the registered store
//   read through the output register, one merged term per cycle while out_tready is
//   high; a run has n <= 32 items; the input stays closed until the last is emitted
// reset (rst_n low, synchronous): counts, drop flag, pointers and output valid clear;
//   store contents are not cleared and need no sweep
module sparse_polynomial_adder
  import spa_pkg::*;
#(
  parameter int MAX_TERMS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // term_coefficient[15:0], term_exponent[31:16]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // sum_coefficient[16:0], sum_exponent[32:17], zero pad
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // empty_result[0], overflow[1]
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt1_r, cnt1_nxt, cnt2_r, cnt2_nxt;
  logic [CW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [RES_CNT_W-1:0] k_r, k_nxt;
  logic dropped_r, dropped_nxt;

  logic               out_valid_r;
  logic signed [16:0] out_coef_r;
  logic [15:0]        out_exp_r;
  logic               out_last_r, out_empty_r, out_ovf_r;

  logic               emit, e_last, e_empty;
  logic signed [16:0] e_coef;
  logic [15:0]        e_exp;
  logic               we1, we2;
  term_t              wr_term, rd1, rd2;
  logic               a_has, b_has, a_more, b_more, out_free, in_acc;
  logic [CW-1:0]      a_adv, b_adv;

  assign wr_term.coefficient = in_tdata[15:0];
  assign wr_term.exponent    = in_tdata[31:16];

  spa_term_store #(.DEPTH(MAX_TERMS), .AW(AW)) u_first (
    .clk     (clk),
    .wr_en   (we1),
    .wr_addr (cnt1_r[AW-1:0]),
    .wr_term (wr_term),
    .rd_addr (a_nxt[AW-1:0]),
    .rd_term (rd1)
  );

  spa_term_store #(.DEPTH(MAX_TERMS), .AW(AW)) u_second (
    .clk     (clk),
    .wr_en   (we2),
    .wr_addr (cnt2_r[AW-1:0]),
    .wr_term (wr_term),
    .rd_addr (b_nxt[AW-1:0]),
    .rd_term (rd2)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign a_has     = a_r < cnt1_r;
  assign b_has     = b_r < cnt2_r;

  always_comb begin
    state_nxt   = state_r;
    cnt1_nxt    = cnt1_r;
    cnt2_nxt    = cnt2_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    k_nxt       = k_r;
    dropped_nxt = dropped_r;
    we1         = 1'b0;
    we2         = 1'b0;
    emit        = 1'b0;
    e_coef      = '0;
    e_exp       = '0;
    e_last      = 1'b0;
    e_empty     = 1'b0;
    a_adv       = a_r;
    b_adv       = b_r;
    a_more      = 1'b0;
    b_more      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            REQ_LOAD_FIRST: begin
              if (cnt1_r < CW'(MAX_TERMS)) begin
                we1      = 1'b1;
                cnt1_nxt = cnt1_r + 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            REQ_LOAD_SECOND: begin
              if (cnt2_r < CW'(MAX_TERMS)) begin
                we2      = 1'b1;
                cnt2_nxt = cnt2_r + 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            REQ_COMPUTE: begin
              state_nxt = ST_MERGE;
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (out_free) begin
          emit = 1'b1;
          if (!a_has && !b_has) begin
            // nothing loaded on either side
            e_empty = 1'b1;
            e_last  = 1'b1;
          end else begin
            if (a_has && b_has && (rd1.exponent == rd2.exponent)) begin
              e_coef = {rd1.coefficient[15], rd1.coefficient}
                     + {rd2.coefficient[15], rd2.coefficient};
              e_exp  = rd1.exponent;
              a_adv  = a_r + 1'b1;
              b_adv  = b_r + 1'b1;
            end else if (a_has && (!b_has || (rd1.exponent > rd2.exponent))) begin
              e_coef = {rd1.coefficient[15], rd1.coefficient};
              e_exp  = rd1.exponent;
              a_adv  = a_r + 1'b1;
            end else begin
              e_coef = {rd2.coefficient[15], rd2.coefficient};
              e_exp  = rd2.exponent;
              b_adv  = b_r + 1'b1;
            end
            a_more = a_adv < cnt1_r;
            b_more = b_adv < cnt2_r;
            e_last = !(a_more || b_more) || (k_r == RES_CNT_W'(MAX_RESULTS - 1));
          end
          a_nxt = a_adv;
          b_nxt = b_adv;
          k_nxt = k_r + 1'b1;
          if (e_last) begin
            state_nxt   = ST_IDLE;
            cnt1_nxt    = '0;
            cnt2_nxt    = '0;
            dropped_nxt = 1'b0;
            a_nxt       = '0;
            b_nxt       = '0;
            k_nxt       = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt1_r    <= '0;
      cnt2_r    <= '0;
      a_r       <= '0;
      b_r       <= '0;
      k_r       <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt1_r    <= cnt1_nxt;
      cnt2_r    <= cnt2_nxt;
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      k_r       <= k_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_coef_r  <= e_coef;
      out_exp_r   <= e_exp;
      out_last_r  <= e_last;
      out_empty_r <= e_empty;
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_exp_r, out_coef_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_empty_r};

endmodule

### design/spa_checker.sv
`include "sparse_polynomial_adder_defines.svh"

module spa_checker
  import spa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // a stalled result word holds
  `SPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
  // the empty marker closes its run on its own
  `SPA_ASSERT_NOW(a_empty_last, clk, rst_n, out_tvalid && out_tuser[0], out_tlast && (out_tdata == 40'd0))
  // an accepted compute request closes the input
  `SPA_ASSERT_NEXT(a_compute_blocks, clk, rst_n, in_tvalid && in_tready && (in_tuser == REQ_COMPUTE), !in_tready)
  // input reopens only after the last word of a run was handed to the output
  `SPA_ASSERT_NOW(a_reopen_after_last, clk, rst_n, !$past(in_tready) && in_tready, out_tvalid && out_tlast)

endmodule

bind sparse_polynomial_adder spa_checker u_spa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import spa_pkg::*;
();

  localparam int MAX_TERMS = 16;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int WORD_TARGET = 280;

  typedef struct {
    logic signed [16:0] coef;
    logic [15:0]        expo;
    bit                 last;
    bit                 empty;
    bit                 ovf;
  } merged_term_t;

  class term_merge_tracker;
    logic [15:0] first_coef [MAX_TERMS];
    logic [15:0] first_exp [MAX_TERMS];
    logic [15:0] second_coef [MAX_TERMS];
    logic [15:0] second_exp [MAX_TERMS];
    int first_count;
    int second_count;
    bit dropped;
    merged_term_t due_terms[$];
    int mismatches;
    int merges;
    int merges_with_drop;
    int terms_checked;

    function new();
      first_count = 0;
      second_count = 0;
      dropped = 0;
      mismatches = 0;
      merges = 0;
      merges_with_drop = 0;
      terms_checked = 0;
    endfunction

    function logic [16:0] widen(logic [15:0] c);
      return {c[15], c};
    endfunction

    function void push_term(logic [16:0] coef, logic [15:0] expo);
      merged_term_t t;
      t.coef = coef;
      t.expo = expo;
      t.last = 0;
      t.empty = 0;
      t.ovf = dropped;
      due_terms.push_back(t);
    endfunction

    function void note_word(logic [1:0] req, logic [15:0] coef, logic [15:0] expo);
      int a;
      int b;
      int k;
      merged_term_t t;
      a = 0;
      b = 0;
      k = 0;
      case (req)
        REQ_LOAD_FIRST: begin
          if (first_count < MAX_TERMS) begin
            first_coef[first_count] = coef;
            first_exp[first_count] = expo;
            first_count++;
          end else begin
            dropped = 1;
          end
        end
        REQ_LOAD_SECOND: begin
          if (second_count < MAX_TERMS) begin
            second_coef[second_count] = coef;
            second_exp[second_count] = expo;
            second_count++;
          end else begin
            dropped = 1;
          end
        end
        REQ_COMPUTE: begin
          merges++;
          if (dropped) merges_with_drop++;
          if (first_count == 0 && second_count == 0) begin
            t.coef = '0;
            t.expo = '0;
            t.last = 1;
            t.empty = 1;
            t.ovf = dropped;
            due_terms.push_back(t);
          end else begin
            while (k < MAX_RESULTS && (a < first_count || b < second_count)) begin
              if (a < first_count && b < second_count && first_exp[a] == second_exp[b]) begin
                push_term(widen(first_coef[a]) + widen(second_coef[b]), first_exp[a]);
                a++;
                b++;
              end else if (a < first_count &&
                           (b >= second_count || first_exp[a] > second_exp[b])) begin
                push_term(widen(first_coef[a]), first_exp[a]);
                a++;
              end else begin
                push_term(widen(second_coef[b]), second_exp[b]);
                b++;
              end
              k++;
            end
            due_terms[due_terms.size() - 1].last = 1;
          end
          first_count = 0;
          second_count = 0;
          dropped = 0;
        end
        default: begin
          // unknown request leaves everything as it was
        end
      endcase
    endfunction

    function void check_term(logic [39:0] data, logic last, logic [1:0] user);
      merged_term_t want;
      logic signed [16:0] got_coef;
      logic [15:0] got_exp;
      got_coef = data[16:0];
      got_exp = data[32:17];
      if (due_terms.size() == 0) begin
        $error("result word with nothing due: coef %0d exp %0d", got_coef, got_exp);
        mismatches++;
        return;
      end
      want = due_terms.pop_front();
      terms_checked++;
      if (got_coef !== want.coef) begin
        $error("sum_coefficient: expected %0d, got %0d", want.coef, got_coef);
        mismatches++;
      end
      if (got_exp !== want.expo) begin
        $error("sum_exponent: expected %0d, got %0d", want.expo, got_exp);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_term: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
      if (user[0] !== want.empty) begin
        $error("empty_result: expected %0d, got %0d", want.empty, user[0]);
        mismatches++;
      end
      if (user[1] !== want.ovf) begin
        $error("overflow: expected %0d, got %0d", want.ovf, user[1]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // term_coefficient[15:0], term_exponent[31:16]
  logic [1:0]  in_tuser;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // sum_coefficient[16:0], sum_exponent[32:17], zero pad
  logic        out_tlast;
  logic [1:0]  out_tuser;  // empty_result[0], overflow[1]

  term_merge_tracker tracker;
  int words_sent = 0;
  int stall_cycles = 0;
  bit no_idle;

  sparse_polynomial_adder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(logic [1:0] req, logic [15:0] coef, logic [15:0] expo);
    int gap;
    term_t t;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    t.exponent = expo;
    t.coefficient = coef;
    in_tvalid <= 1'b1;
    in_tdata <= t;
    in_tuser <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_word(req, coef, expo);
    if (req != REQ_UNKNOWN) words_sent++;
    @(negedge clk);
  endtask

  task automatic run_directed();
    no_idle = 0;
    // both stores empty, operands ignored
    send_word(REQ_COMPUTE, 16'h7fff, 16'hffff);
    send_word(REQ_UNKNOWN, 16'h8000, 16'h0000);
    // most negative sum, zero sum kept, most positive sum, one-sided term
    send_word(REQ_LOAD_FIRST, 16'h8000, 16'hffff);
    send_word(REQ_LOAD_SECOND, 16'h8000, 16'hffff);
    send_word(REQ_LOAD_FIRST, 16'd5, 16'd1000);
    send_word(REQ_LOAD_SECOND, 16'hfffb, 16'd1000);
    send_word(REQ_LOAD_SECOND, 16'd1, 16'd500);
    send_word(REQ_LOAD_FIRST, 16'h7fff, 16'h0000);
    send_word(REQ_LOAD_SECOND, 16'h7fff, 16'h0000);
    send_word(REQ_UNKNOWN, 16'hffff, 16'hffff);
    send_word(REQ_COMPUTE, 16'h0000, 16'h0000);
    // leftovers from one side only
    send_word(REQ_LOAD_FIRST, 16'h1234, 16'd300);
    send_word(REQ_LOAD_FIRST, 16'hedcb, 16'd7);
    send_word(REQ_COMPUTE, 16'h5555, 16'haaaa);
    send_word(REQ_LOAD_SECOND, 16'h0001, 16'h8000);
    send_word(REQ_COMPUTE, 16'haaaa, 16'h5555);
    // counts cleared by the previous merge
    send_word(REQ_COMPUTE, 16'hffff, 16'h0000);
  endtask

  task automatic load_and_merge();
    int r;
    int n_union;
    int step;
    int side;
    bit broken;
    bit heavy;
    logic [15:0] e;
    term_t t;
    term_t first_q[$];
    term_t second_q[$];
    r = $urandom_range(0, 99);
    heavy = (r >= 76 && r < 88);
    broken = (r >= 88);
    no_idle = ($urandom_range(0, 4) == 0);
    if (heavy) n_union = $urandom_range(17, 20);
    else if ($urandom_range(0, 7) == 0) n_union = $urandom_range(8, 16);
    else n_union = $urandom_range(0, 5);
    e = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom_range(0, 65535));
    for (int i = 0; i < n_union; i++) begin
      if (broken) e = 16'($urandom_range(0, 65535));
      t.exponent = e;
      t.coefficient = 16'($urandom());
      r = $urandom_range(0, 9);
      if (heavy || r >= 6) begin
        first_q.push_back(t);
        // cancelling pair now and then
        if ($urandom_range(0, 3) == 0) t.coefficient = -t.coefficient;
        else t.coefficient = 16'($urandom());
        second_q.push_back(t);
      end else if (r < 3) begin
        first_q.push_back(t);
      end else begin
        second_q.push_back(t);
      end
      if (!broken) begin
        if (e == 0) break;
        step = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, 5000);
        if (step > e) e = 0;
        else e = e - 16'(step);
      end
    end
    while (first_q.size() + second_q.size() > 0) begin
      if ($urandom_range(0, 9) == 0) send_word(REQ_UNKNOWN, 16'($urandom()), 16'($urandom()));
      side = $urandom_range(0, 1);
      if (second_q.size() == 0 || (side == 0 && first_q.size() > 0)) begin
        t = first_q.pop_front();
        send_word(REQ_LOAD_FIRST, t.coefficient, t.exponent);
      end else begin
        t = second_q.pop_front();
        send_word(REQ_LOAD_SECOND, t.coefficient, t.exponent);
      end
    end
    if ($urandom_range(0, 9) == 0) send_word(REQ_UNKNOWN, 16'($urandom()), 16'($urandom()));
    send_word(REQ_COMPUTE, 16'($urandom()), 16'($urandom()));
  endtask

  // result side back-pressure
  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_term(out_tdata, out_tlast, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    tracker = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    no_idle = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    while (words_sent < WORD_TARGET) load_and_merge();
    in_tvalid <= 1'b0;
    while (tracker.due_terms.size() != 0) @(posedge clk);
    // anything arriving now is unexpected and gets flagged by check_term
    repeat (40) @(posedge clk);
    $display("covered %0d load and merge words, %0d result words checked",
             words_sent, tracker.terms_checked);
    $display("over %0d merge requests, %0d of them after dropped terms",
             tracker.merges, tracker.merges_with_drop);
    if (tracker.due_terms.size() != 0) begin
      $error("%0d result words never arrived", tracker.due_terms.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
